// ===== rtl/core/lsbse_pkg.sv =====
package lsbse_pkg;

	localparam int KIND_W = 2;
	localparam int SEC_W  = 3;
	localparam int IDX_W  = 5;
	localparam int CNT_W  = 32;

	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COVER   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START   = 2'd2;

	localparam logic [SEC_W-1:0] SEC_HEADER    = 3'd0;
	localparam logic [SEC_W-1:0] SEC_MAGIC_LEN = 3'd1;
	localparam logic [SEC_W-1:0] SEC_MAGIC     = 3'd2;
	localparam logic [SEC_W-1:0] SEC_EXT_LEN   = 3'd3;
	localparam logic [SEC_W-1:0] SEC_EXT       = 3'd4;
	localparam logic [SEC_W-1:0] SEC_SIZE      = 3'd5;
	localparam logic [SEC_W-1:0] SEC_DATA      = 3'd6;
	localparam logic [SEC_W-1:0] SEC_TAIL      = 3'd7;

	localparam logic [1:0] REG_MAGIC_LEN = 2'd0;
	localparam logic [1:0] REG_EXT_LEN   = 2'd1;
	localparam logic [1:0] REG_SECRET    = 2'd2;

	typedef struct packed {
		logic [SEC_W-1:0] sec;
		logic [CNT_W-1:0] cnt;
		logic [IDX_W-1:0] bidx;
		logic [7:0]       held;
		logic             held_v;
		logic [7:0]       act;
		logic             ovr;
	} emb_state_t;

	typedef struct packed {
		logic             valid;
		logic [7:0]       out_byte;
		logic [SEC_W-1:0] section;
		logic             starved;
		logic             overrun;
	} emb_result_t;

	typedef struct packed {
		logic [7:0]  magic_len;
		logic [7:0]  ext_len;
		logic [31:0] secret;
	} emb_cfg_t;

endpackage

// ===== rtl/core/lsbse_embed.sv =====
module lsbse_embed import lsbse_pkg::*; #(
	parameter int HEADER_BYTES = 54,
	parameter int LENGTH_BITS  = 32
) (
	input  emb_state_t        st,
	input  emb_cfg_t          cfg,
	input  logic [KIND_W-1:0] kind,
	input  logic [7:0]        value,
	output emb_state_t        nxt,
	output emb_result_t       res
);

	logic [SEC_W-1:0] s;
	logic [CNT_W-1:0] cnt;
	logic [IDX_W-1:0] bidx;
	logic [CNT_W-1:0] plen;
	logic             is_char;
	logic [7:0]       ch;
	logic             bit_v;

	always_comb begin
		is_char = (st.sec == SEC_MAGIC) || (st.sec == SEC_EXT) || (st.sec == SEC_DATA);
		case (st.sec)
			SEC_MAGIC_LEN, SEC_MAGIC: plen = {24'd0, cfg.magic_len};
			SEC_EXT_LEN, SEC_EXT:     plen = {24'd0, cfg.ext_len};
			default:                  plen = cfg.secret;
		endcase
	end

	always_comb begin
		nxt   = st;
		res   = '0;
		s     = st.sec;
		cnt   = st.cnt;
		bidx  = st.bidx;
		ch    = st.act;
		bit_v = 1'b0;
		res.out_byte = value;
		unique case (kind)
			KIND_PAYLOAD: begin
				if (st.held_v) begin
					nxt.ovr = 1'b1;
				end
				nxt.held   = value;
				nxt.held_v = 1'b1;
			end
			KIND_START: begin
				nxt.sec  = SEC_HEADER;
				nxt.cnt  = '0;
				nxt.bidx = '0;
				nxt.act  = '0;
				nxt.ovr  = 1'b0;
			end
			KIND_COVER: begin
				// leave a finished header or character part
				if (st.sec == SEC_HEADER) begin
					if (st.cnt >= CNT_W'(HEADER_BYTES)) begin
						s    = SEC_MAGIC_LEN;
						cnt  = '0;
						bidx = '0;
					end
				end else if (is_char && st.bidx == '0 && st.cnt >= plen) begin
					s    = st.sec + SEC_W'(1);
					cnt  = '0;
					bidx = '0;
				end
				res.valid = 1'b1;
				res.section = s;
				case (s)
					SEC_HEADER: begin
						cnt = cnt + CNT_W'(1);
					end
					SEC_MAGIC_LEN, SEC_EXT_LEN, SEC_SIZE: begin
						case (s)
							SEC_MAGIC_LEN: bit_v = cfg.magic_len[bidx[2:0]] & (bidx < 5'd8);
							SEC_EXT_LEN:   bit_v = cfg.ext_len[bidx[2:0]] & (bidx < 5'd8);
							default:       bit_v = cfg.secret[bidx];
						endcase
						res.out_byte = {value[7:1], bit_v};
						if (bidx >= IDX_W'(LENGTH_BITS - 1)) begin
							s    = s + SEC_W'(1);
							cnt  = '0;
							bidx = '0;
						end else begin
							bidx = bidx + IDX_W'(1);
						end
					end
					SEC_MAGIC, SEC_EXT, SEC_DATA: begin
						if (bidx == '0) begin
							if (st.held_v) begin
								ch = st.held;
								nxt.held_v = 1'b0;
							end else begin
								ch = '0;
								res.starved = 1'b1;
							end
						end
						bit_v = ch[bidx[2:0]];
						res.out_byte = {value[7:1], bit_v};
						if (bidx[2:0] == 3'd7) begin
							bidx = '0;
							cnt  = cnt + CNT_W'(1);
						end else begin
							bidx = bidx + IDX_W'(1);
						end
					end
					default: begin
					end
				endcase
				nxt.sec  = s;
				nxt.cnt  = cnt;
				nxt.bidx = bidx;
				nxt.act  = ch;
				res.overrun = st.ovr;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/lsb_stego_frame_embedder.sv =====
// Hides a framed payload in the least significant bits of a stream of cover image
// bytes. Each input beat is a payload byte, a cover byte or a start-of-image marker;
// only cover bytes give an output beat. After HEADER_BYTES header bytes come the
// magic length, magic characters, extension length, extension characters, secret
// size and secret bytes, one bit per cover byte, LSB first; lengths take LENGTH_BITS
// cover bytes. Payload bytes must arrive ahead of the cover bytes that carry them and
// are held one deep; a missing byte embeds zeros and raises starved, an overwritten
// one sets the sticky overrun flag until the next start. Throughput is one beat per
// clock while out_stall is low; one input register comes first, then the section/bit
// counter update and bit select feeding the output register. The user must write
// registers only while the block is idle; the block itself does not enforce this.
module lsb_stego_frame_embedder import lsbse_pkg::*; #(
	parameter int HEADER_BYTES = 54,
	parameter int LENGTH_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [31:0]       wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [7:0]        value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic [SEC_W-1:0]  section,
	output logic              starved,
	output logic              overrun
);

	emb_cfg_t          cfg_q;
	emb_state_t        state_q;
	emb_state_t        state_nxt;
	emb_result_t       res;
	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [7:0]        value_s1;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [SEC_W-1:0]  section_q;
	logic              starved_q;
	logic              overrun_q;
	logic              out_free;
	logic              adv;
	logic              accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_len <= 8'd0;
			cfg_q.ext_len   <= 8'd4;
			cfg_q.secret    <= 32'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAGIC_LEN: cfg_q.magic_len <= wr_data[7:0];
				REG_EXT_LEN:   cfg_q.ext_len   <= wr_data[7:0];
				REG_SECRET:    cfg_q.secret    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && ((kind_s1 != KIND_COVER) || out_free);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			value_s1 <= value;
		end
	end

	lsbse_embed #(
		.HEADER_BYTES(HEADER_BYTES),
		.LENGTH_BITS (LENGTH_BITS)
	) u_embed (
		.st   (state_q),
		.cfg  (cfg_q),
		.kind (kind_s1),
		.value(value_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_byte_q <= res.out_byte;
			section_q  <= res.section;
			starved_q  <= res.starved;
			overrun_q  <= res.overrun;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign section   = section_q;
	assign starved   = starved_q;
	assign overrun   = overrun_q;

`ifndef NO_ASSERTIONS
	a_char_bidx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.sec == SEC_MAGIC || state_q.sec == SEC_EXT || state_q.sec == SEC_DATA)
		|-> (state_q.bidx < 5'd8))
		else $error("bit index out of range in character part");

	a_header_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.sec == SEC_HEADER)
		|-> (state_q.bidx == '0 && state_q.cnt <= CNT_W'(HEADER_BYTES)))
		else $error("header counter past header length");

	a_starved_sec: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.valid && res.starved)
		|-> (res.section == SEC_MAGIC || res.section == SEC_EXT || res.section == SEC_DATA))
		else $error("starved outside a character part");

	a_ovr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q.ovr) |-> $past(adv && kind_s1 == KIND_START))
		else $error("overrun flag cleared without start beat");
`endif

endmodule

// ===== tb/lsbse_checker.sv =====
`timescale 1ns / 100ps

module lsbse_checker import lsbse_pkg::*; #(
	parameter int HEADER_BYTES = 54,
	parameter int LENGTH_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [31:0]       wr_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [7:0]        value,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        out_byte,
	input  logic [SEC_W-1:0]  section,
	input  logic              starved,
	input  logic              overrun,
	output int                errors,
	output int                pending,
	output int                checked,
	output logic [7:0]        sec_seen,
	output int                starve_cnt,
	output int                overrun_cnt
);

	typedef struct packed {
		logic [7:0]       pix;
		logic [SEC_W-1:0] sec;
		logic             starv;
		logic             ovr;
	} beat_t;

	emb_cfg_t         cfg;
	logic [SEC_W-1:0] cur_sec;
	logic [31:0]      cnt;
	logic [5:0]       bidx;
	logic [7:0]       held;
	logic             held_v;
	logic [7:0]       act;
	logic             ovr_f;
	beat_t            stego_q[$];

	function automatic logic [31:0] part_len(input logic [SEC_W-1:0] s);
		if (s == SEC_MAGIC_LEN || s == SEC_MAGIC)
			return {24'd0, cfg.magic_len};
		if (s == SEC_EXT_LEN || s == SEC_EXT)
			return {24'd0, cfg.ext_len};
		return cfg.secret;
	endfunction

	task automatic enter(input logic [SEC_W-1:0] s);
		cur_sec = s;
		cnt = 32'd0;
		bidx = 6'd0;
	endtask

	task automatic settle();
		bit moved;
		moved = 1'b1;
		while (moved) begin
			moved = 1'b0;
			if (cur_sec == SEC_HEADER) begin
				if (cnt >= HEADER_BYTES) begin
					enter(SEC_MAGIC_LEN);
					moved = 1'b1;
				end
			end else if ((cur_sec == SEC_MAGIC || cur_sec == SEC_EXT || cur_sec == SEC_DATA)
					&& bidx == 6'd0 && cnt >= part_len(cur_sec)) begin
				enter(cur_sec + 3'd1);
				moved = 1'b1;
			end
		end
	endtask

	task automatic embed_cover(input logic [7:0] v, output beat_t r);
		logic [31:0] len;
		r.pix = v;
		r.starv = 1'b0;
		settle();
		r.sec = cur_sec;
		case (cur_sec)
			SEC_HEADER: cnt = cnt + 32'd1;
			SEC_MAGIC_LEN, SEC_EXT_LEN, SEC_SIZE: begin
				len = part_len(cur_sec);
				r.pix[0] = len[bidx[4:0]];
				bidx = bidx + 6'd1;
				if (bidx >= LENGTH_BITS || bidx >= 32)
					enter(cur_sec + 3'd1);
			end
			SEC_MAGIC, SEC_EXT, SEC_DATA: begin
				if (bidx == 6'd0) begin
					if (held_v) begin
						act = held;
						held_v = 1'b0;
					end else begin
						act = 8'd0;
						r.starv = 1'b1;
					end
				end
				r.pix[0] = act[bidx[2:0]];
				bidx = bidx + 6'd1;
				if (bidx >= 8) begin
					bidx = 6'd0;
					cnt = cnt + 32'd1;
				end
			end
			default: ;
		endcase
		r.ovr = ovr_f;
	endtask

	task automatic check_beat();
		beat_t got;
		beat_t want;
		got = '{pix: out_byte, sec: section, starv: starved, ovr: overrun};
		if (stego_q.size() == 0) begin
			if (errors < 10)
				$display("%0t: output beat %h/%0d/%b/%b with nothing expected",
					$time, got.pix, got.sec, got.starv, got.ovr);
			errors++;
		end else begin
			want = stego_q.pop_front();
			checked++;
			sec_seen[want.sec] = 1'b1;
			if (want.starv) starve_cnt++;
			if (want.ovr) overrun_cnt++;
			if (got.pix !== want.pix || got.sec !== want.sec
					|| got.starv !== want.starv || got.ovr !== want.ovr) begin
				if (errors < 10)
					$display("%0t: mismatch byte %h/%h section %0d/%0d starved %b/%b overrun %b/%b",
						$time, want.pix, got.pix, want.sec, got.sec,
						want.starv, got.starv, want.ovr, got.ovr);
				errors++;
			end
		end
	endtask

	task automatic take_item();
		beat_t w;
		case (kind)
			KIND_PAYLOAD: begin
				if (held_v) ovr_f = 1'b1;
				held = value;
				held_v = 1'b1;
			end
			KIND_START: begin
				enter(SEC_HEADER);
				act = 8'd0;
				ovr_f = 1'b0;
			end
			KIND_COVER: begin
				embed_cover(value, w);
				stego_q.push_back(w);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{magic_len: 8'd0, ext_len: 8'd4, secret: 32'd0};
			enter(SEC_HEADER);
			held = 8'd0;
			held_v = 1'b0;
			act = 8'd0;
			ovr_f = 1'b0;
			stego_q.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			sec_seen = 8'd0;
			starve_cnt = 0;
			overrun_cnt = 0;
		end else begin
			if (out_valid && !out_stall)
				check_beat();
			if (wr_en) begin
				case (wr_index)
					REG_MAGIC_LEN: cfg.magic_len = wr_data[7:0];
					REG_EXT_LEN:   cfg.ext_len = wr_data[7:0];
					REG_SECRET:    cfg.secret = wr_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_item();
			pending = stego_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import lsbse_pkg::*;

	localparam int HDR         = 54;
	localparam int LBITS       = 32;
	localparam int ITEMS       = 1850;
	localparam int CHAR_CAP    = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 400000;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
	localparam logic [1:0]        REG_NONE  = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [1:0]        wr_index;
	logic [31:0]       wr_data;
	logic              in_valid;
	logic              in_stall;
	logic [KIND_W-1:0] kind;
	logic [7:0]        value;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        out_byte;
	logic [SEC_W-1:0]  section;
	logic              starved;
	logic              overrun;

	int         errors;
	int         pending;
	int         checked;
	logic [7:0] sec_seen;
	int         starve_cnt;
	int         overrun_cnt;

	int          cycles = 0;
	int          beats = 0;
	int          images = 0;
	bit          calm;
	bit          hold_req;
	logic [7:0]  mg;
	logic [7:0]  ex;
	logic [31:0] sz;

	lsb_stego_frame_embedder #(.HEADER_BYTES(HDR), .LENGTH_BITS(LBITS)) u_dut (.*);

	lsbse_checker #(.HEADER_BYTES(HDR), .LENGTH_BITS(LBITS)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= LIMIT);
		$display("status: fail");
		$finish;
	end

	// output side back-pressure, with one long hold when asked
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 13);
			end
		end
	end

	task automatic put_beat(input logic [KIND_W-1:0] k, input logic [7:0] v);
		while (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (k != KIND_NONE) beats++;
	endtask

	task automatic put_cover();
		if ($urandom_range(99) < 2)
			put_beat(KIND_NONE, 8'($urandom_range(255)));
		put_beat(KIND_COVER, 8'($urandom_range(255)));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [31:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(negedge clk);
	endtask

	task automatic set_cfg(input logic [7:0] m, input logic [7:0] e, input logic [31:0] s);
		mg = m;
		ex = e;
		sz = s;
		if ($urandom_range(1)) put_reg(REG_NONE, $urandom);
		put_reg(REG_MAGIC_LEN, {24'($urandom_range(32'hFF_FFFF)), m});
		put_reg(REG_EXT_LEN, {24'($urandom_range(32'hFF_FFFF)), e});
		put_reg(REG_SECRET, s);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_len();
		repeat (LBITS) put_cover();
	endtask

	// one character part; may shrink its own length in the middle of a character
	task automatic send_chars(input logic [31:0] n, input logic [1:0] reg_id, input bit shrink,
			output bit cut);
		logic [31:0] lim;
		int          i;
		int          k;
		int          r;
		lim = (n > CHAR_CAP) ? CHAR_CAP : n;
		cut = (n > CHAR_CAP);
		k = (shrink && lim > 0) ? $urandom_range(lim - 1) : -1;
		i = 0;
		while (i < lim) begin
			r = $urandom_range(99);
			if (r >= 6) put_beat(KIND_PAYLOAD, 8'($urandom_range(255)));
			if (r >= 6 && r < 12) put_beat(KIND_PAYLOAD, 8'($urandom_range(255)));
			if (i == k) begin
				repeat (3) put_cover();
				wait_idle();
				lim = $urandom_range(i);
				cut = 1'b0;
				case (reg_id)
					REG_MAGIC_LEN: set_cfg(lim[7:0], ex, sz);
					REG_EXT_LEN:   set_cfg(mg, lim[7:0], sz);
					default:       set_cfg(mg, ex, lim);
				endcase
				repeat (5) put_cover();
			end else begin
				repeat (8) put_cover();
			end
			i++;
		end
	endtask

	task automatic send_image(input bit pressure);
		bit cut;
		put_beat(KIND_START, 8'($urandom_range(255)));
		repeat (HDR) put_cover();
		if (pressure) hold_req = 1'b1;
		send_len();
		send_chars({24'd0, mg}, REG_MAGIC_LEN, $urandom_range(5) == 0, cut);
		if (cut) return;
		if ($urandom_range(4) == 0) begin
			wait_idle();
			set_cfg(mg, 8'($urandom_range(5)), $urandom_range(8));
		end
		send_len();
		send_chars({24'd0, ex}, REG_EXT_LEN, $urandom_range(5) == 0, cut);
		if (cut) return;
		send_len();
		send_chars(sz, REG_SECRET, $urandom_range(5) == 0, cut);
		if (cut) return;
		repeat ($urandom_range(12)) put_cover();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		kind = '0;
		value = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		mg = 8'd0;
		ex = 8'd4;
		sz = 32'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put_beat(KIND_NONE, 8'hFF);
		put_beat(KIND_COVER, 8'h00);
		put_beat(KIND_COVER, 8'hFF);
		put_beat(KIND_PAYLOAD, 8'h00);
		put_beat(KIND_PAYLOAD, 8'hFF);
		put_beat(KIND_COVER, 8'hAA);
		put_beat(KIND_START, 8'hFF);
		put_beat(KIND_COVER, 8'h55);
		put_beat(KIND_NONE, 8'h00);
		put_beat(KIND_PAYLOAD, 8'h81);
		put_beat(KIND_START, 8'h00);

		while (beats < ITEMS) begin
			images++;
			calm = (images == 5 || images == 6);
			if (images > 1) begin
				wait_idle();
				case (images)
					2: set_cfg(8'hFF, 8'hFF, 32'hFFFF_FFFF);
					4: set_cfg(8'd0, 8'd0, 32'd0);
					default: begin
						if ($urandom_range(5) == 0)
							set_cfg(8'($urandom_range(3)), 8'($urandom_range(3)), $urandom);
						else
							set_cfg(8'($urandom_range(4)), 8'($urandom_range(4)),
								$urandom_range(6));
					end
				endcase
			end
			send_image(images == 3);
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(6, 1))
					put_beat(KIND_W'($urandom_range(3)), 8'($urandom_range(255)));
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("run covered %0d input beats over %0d images, %0d output beats checked",
			beats, images, checked);
		$display("sections seen %b, starved beats %0d, beats with overrun set %0d",
			sec_seen, starve_cnt, overrun_cnt);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
